// ===== hdl/d8f_pkg.sv =====
`default_nettype none

package d8f_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ELEV_W    = 32;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WDT_W     = COL_W + 1;
    localparam int ROW_W     = 16;
    localparam int HGT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CIDX_W    = 2;
    localparam int DIR_W     = 4;
    localparam int NUM_DIR   = 8;
    localparam int SEL_W     = 3;
    localparam int WGT_W     = 17;
    localparam int DROP_W    = ELEV_W + 1;
    localparam int KEY_W     = DROP_W + WGT_W;

    // 1/sqrt(2) in q16, straight neighbors weigh 2^16
    localparam logic signed [WGT_W-1:0] DIAG_WEIGHT = WGT_W'(46341);
    localparam int STRAIGHT_SHIFT = 16;

    localparam logic [DIR_W-1:0] NO_FLOW = DIR_W'(8);

    localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = CIDX_W'(1);

    localparam logic [WDT_W-1:0] WIDTH_RESET  = WDT_W'(1024);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(1024);
    localparam logic [WDT_W-1:0] WIDTH_MIN    = WDT_W'(3);
    localparam logic [WDT_W-1:0] WIDTH_MAX    = WDT_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] HEIGHT_MIN   = HGT_W'(3);

    typedef logic signed [DROP_W-1:0] t_drop;
    typedef logic signed [KEY_W-1:0]  t_key;

    // what travels alongside a cell through the pipe
    typedef struct packed {
        logic             interior;
        logic [COL_W-1:0] cx;
        logic [ROW_W-1:0] cy;
    } t_tag;

    function automatic t_drop drop_of(input logic [ELEV_W-1:0] c,
                                      input logic [ELEV_W-1:0] nb);
        t_drop dc;
        t_drop dn;
        dc = {c[ELEV_W-1], c};
        dn = {nb[ELEV_W-1], nb};
        return dc - dn;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/d8_flow_direction_unit.sv =====
`default_nettype none

// channel  | valid   | stall   | payload
// ---------+---------+---------+------------------------------------------
// sample   | i_valid | o_stall | i_elevation (signed q16.16)
// result   | o_valid | i_stall | o_direction, o_cell_x, o_cell_y
// config   | i_cfg_we|  none   | i_cfg_index, i_cfg_data
//
// one sample beat per cycle sustained while i_stall does not hold the pipe; a result
// passes the registered stages line-store read, drops, slope keys, pairwise pick, final pick
// i_rst_n is synchronous: counters, window and stage valids clear, grid goes to 1024x1024
// each stage holds only when it is full and the one after it holds, so
// bubbles close up and the stages behind a result waiting on i_stall still fill

module d8_flow_direction_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output      logic                               o_stall,
    input  wire logic [d8f_pkg::ELEV_W-1:0]         i_elevation,
    output      logic                               o_valid,
    input  wire logic                               i_stall,
    output      logic [d8f_pkg::DIR_W-1:0]          o_direction,
    output      logic [9:0]                         o_cell_x,
    output      logic [15:0]                        o_cell_y,
    input  wire logic                               i_cfg_we,
    input  wire logic [d8f_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire logic [d8f_pkg::CFG_W-1:0]          i_cfg_data
);

    // configuration
    logic [d8f_pkg::WDT_W-1:0] r_grid_width;
    logic [d8f_pkg::HGT_W-1:0] r_grid_height;
    logic [d8f_pkg::WDT_W-1:0] wdt;
    logic [d8f_pkg::HGT_W-1:0] hgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= d8f_pkg::WIDTH_RESET;
            r_grid_height <= d8f_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                d8f_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[d8f_pkg::WDT_W-1:0];
                d8f_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[d8f_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective grid: width clamped to 3..line length, height at least 3
    always_comb begin
        if (r_grid_width < d8f_pkg::WIDTH_MIN) begin
            wdt = d8f_pkg::WIDTH_MIN;
        end else if (r_grid_width > d8f_pkg::WIDTH_MAX) begin
            wdt = d8f_pkg::WIDTH_MAX;
        end else begin
            wdt = r_grid_width;
        end
        hgt = (r_grid_height < d8f_pkg::HEIGHT_MIN) ? d8f_pkg::HEIGHT_MIN : r_grid_height;
    end

    // stage valids: a = sample + line reads, b = drops, c = keys, d = pairs, o = result
    logic r_va, r_vb, r_vc, r_vd, r_vo;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
    logic accept, a_adv, a_emit;
    logic ld_b, ld_c, ld_d, ld_o;

    d8f_pkg::t_tag  a_tag;
    d8f_pkg::t_tag  r_tag_b, r_tag_c, r_tag_d, r_tag_o;
    d8f_pkg::t_drop drop [d8f_pkg::NUM_DIR];
    d8f_pkg::t_key  key  [d8f_pkg::NUM_DIR];

    assign rdy_o  = !r_vo || !i_stall;
    assign rdy_d  = !r_vd || rdy_o;
    assign rdy_c  = !r_vc || rdy_d;
    assign rdy_b  = !r_vb || rdy_c;
    // a beat that yields no result still has to update the window and lines
    assign a_adv  = r_va && (!a_emit || rdy_b);
    assign rdy_a  = !r_va || a_adv;
    assign accept = i_valid && rdy_a;

    assign ld_b = a_adv && a_emit;
    assign ld_c = r_vb && rdy_c;
    assign ld_d = r_vc && rdy_d;
    assign ld_o = r_vd && rdy_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= a_adv && a_emit;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_d) r_vd <= r_vc;
            if (rdy_o) r_vo <= r_vd;
        end
    end

    // cell position and interior flag ride along with the data
    always_ff @(posedge i_clk) begin
        if (ld_b) r_tag_b <= a_tag;
        if (ld_c) r_tag_c <= r_tag_b;
        if (ld_d) r_tag_d <= r_tag_c;
        if (ld_o) r_tag_o <= r_tag_d;
    end

    d8f_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_elevation (i_elevation),
        .i_a_adv     (a_adv),
        .i_wdt       (wdt),
        .i_hgt       (hgt),
        .o_a_emit    (a_emit),
        .o_a_tag     (a_tag),
        .o_drop      (drop)
    );

    d8f_keys u_keys (
        .i_clk  (i_clk),
        .i_ld_b (ld_b),
        .i_ld_c (ld_c),
        .i_drop (drop),
        .o_key  (key)
    );

    d8f_argmax u_argmax (
        .i_clk       (i_clk),
        .i_ld_d      (ld_d),
        .i_ld_o      (ld_o),
        .i_interior  (r_tag_d.interior),
        .i_key       (key),
        .o_direction (o_direction)
    );

    assign o_stall  = !rdy_a;
    assign o_valid  = r_vo;
    assign o_cell_x = 10'(r_tag_o.cx);
    assign o_cell_y = 16'(r_tag_o.cy);

endmodule

`default_nettype wire

// ===== hdl/d8f_window.sv =====
`default_nettype none

module d8f_window (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic [d8f_pkg::ELEV_W-1:0]       i_elevation,
    input  wire logic                             i_a_adv,
    input  wire logic [d8f_pkg::WDT_W-1:0]        i_wdt,
    input  wire logic [d8f_pkg::HGT_W-1:0]        i_hgt,
    output      logic                             o_a_emit,
    output      d8f_pkg::t_tag                    o_a_tag,
    output      d8f_pkg::t_drop                   o_drop [d8f_pkg::NUM_DIR]
);

    logic [d8f_pkg::ELEV_W-1:0] upper_mem  [d8f_pkg::MAX_WIDTH];
    logic [d8f_pkg::ELEV_W-1:0] middle_mem [d8f_pkg::MAX_WIDTH];

    logic [d8f_pkg::COL_W-1:0]  r_col;
    logic [d8f_pkg::ROW_W-1:0]  r_row;
    logic [d8f_pkg::COL_W-1:0]  n_col;
    logic [d8f_pkg::ROW_W-1:0]  n_row;

    logic [d8f_pkg::ELEV_W-1:0] r_rd_up;
    logic [d8f_pkg::ELEV_W-1:0] r_rd_mid;
    logic [d8f_pkg::ELEV_W-1:0] r_a_elev;
    logic [d8f_pkg::COL_W-1:0]  r_a_x;
    logic                       r_a_emit;
    d8f_pkg::t_tag              r_a_tag;
    logic [d8f_pkg::ELEV_W-1:0] r_win [6];

    logic                       n_emit;
    d8f_pkg::t_tag              n_tag;

    // position bookkeeping for the sample being taken
    always_comb begin
        n_emit = (r_col != '0) && (r_row != '0) &&
                 ({1'b0, r_col} < i_wdt) && (r_row < i_hgt);
        n_tag.interior = (r_col > d8f_pkg::COL_W'(1)) && (r_row > d8f_pkg::ROW_W'(1));
        n_tag.cx       = r_col - d8f_pkg::COL_W'(1);
        n_tag.cy       = r_row - d8f_pkg::ROW_W'(1);
        if (({1'b0, r_col} + d8f_pkg::WDT_W'(1)) >= i_wdt) begin
            n_col = '0;
            if (({1'b0, r_row} + 17'd1) >= {1'b0, i_hgt}) begin
                n_row = '0;
            end else begin
                n_row = r_row + d8f_pkg::ROW_W'(1);
            end
        end else begin
            n_col = r_col + d8f_pkg::COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line reads and the sample itself
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_up  <= upper_mem[r_col];
            r_rd_mid <= middle_mem[r_col];
            r_a_elev <= i_elevation;
            r_a_x    <= r_col;
            r_a_emit <= n_emit;
            r_a_tag  <= n_tag;
        end
    end

    // lines shift down one row at the column the beat leaves
    always_ff @(posedge i_clk) begin
        if (i_a_adv) begin
            upper_mem[r_a_x]  <= r_rd_mid;
            middle_mem[r_a_x] <= r_a_elev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_a_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_rd_up;
            r_win[2] <= r_win[3];
            r_win[3] <= r_rd_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= r_a_elev;
        end
    end

    // center is the middle row, one column back; order W NW N NE E SE S SW
    always_comb begin
        o_drop[0] = d8f_pkg::drop_of(r_win[3], r_win[2]);
        o_drop[1] = d8f_pkg::drop_of(r_win[3], r_win[0]);
        o_drop[2] = d8f_pkg::drop_of(r_win[3], r_win[1]);
        o_drop[3] = d8f_pkg::drop_of(r_win[3], r_rd_up);
        o_drop[4] = d8f_pkg::drop_of(r_win[3], r_rd_mid);
        o_drop[5] = d8f_pkg::drop_of(r_win[3], r_a_elev);
        o_drop[6] = d8f_pkg::drop_of(r_win[3], r_win[5]);
        o_drop[7] = d8f_pkg::drop_of(r_win[3], r_win[4]);
    end

    assign o_a_emit = r_a_emit;
    assign o_a_tag  = r_a_tag;

endmodule

`default_nettype wire

// ===== hdl/d8f_keys.sv =====
`default_nettype none

module d8f_keys (
    input  wire logic           i_clk,
    input  wire logic           i_ld_b,
    input  wire logic           i_ld_c,
    input  wire d8f_pkg::t_drop i_drop [d8f_pkg::NUM_DIR],
    output      d8f_pkg::t_key  o_key  [d8f_pkg::NUM_DIR]
);

    d8f_pkg::t_drop r_drop [d8f_pkg::NUM_DIR];
    d8f_pkg::t_key  r_key  [d8f_pkg::NUM_DIR];
    d8f_pkg::t_key  n_key  [d8f_pkg::NUM_DIR];

    always_ff @(posedge i_clk) begin
        if (i_ld_b) begin
            for (int i = 0; i < d8f_pkg::NUM_DIR; i++) begin
                r_drop[i] <= i_drop[i];
            end
        end
    end

    // odd directions are diagonals
    always_comb begin
        for (int i = 0; i < d8f_pkg::NUM_DIR; i++) begin
            if (i % 2 == 1) begin
                n_key[i] = r_drop[i] * d8f_pkg::DIAG_WEIGHT;
            end else begin
                n_key[i] = d8f_pkg::KEY_W'(r_drop[i]) <<< d8f_pkg::STRAIGHT_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_c) begin
            for (int i = 0; i < d8f_pkg::NUM_DIR; i++) begin
                r_key[i] <= n_key[i];
            end
        end
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

// ===== hdl/d8f_argmax.sv =====
`default_nettype none

module d8f_argmax (
    input  wire logic                      i_clk,
    input  wire logic                      i_ld_d,
    input  wire logic                      i_ld_o,
    input  wire logic                      i_interior,
    input  wire d8f_pkg::t_key             i_key [d8f_pkg::NUM_DIR],
    output      logic [d8f_pkg::DIR_W-1:0] o_direction
);

    localparam int HALF = d8f_pkg::NUM_DIR / 2;

    d8f_pkg::t_key             r_key [HALF];
    logic [d8f_pkg::SEL_W-1:0] r_sel [HALF];
    d8f_pkg::t_key             n_key [HALF];
    logic [d8f_pkg::SEL_W-1:0] n_sel [HALF];

    d8f_pkg::t_key             lo_key;
    d8f_pkg::t_key             hi_key;
    logic [d8f_pkg::SEL_W-1:0] lo_sel;
    logic [d8f_pkg::SEL_W-1:0] hi_sel;
    logic [d8f_pkg::SEL_W-1:0] best_sel;
    logic [d8f_pkg::DIR_W-1:0] r_direction;

    // later direction wins only when strictly steeper, so ties keep the earlier one
    always_comb begin
        for (int j = 0; j < HALF; j++) begin
            if (i_key[2*j+1] > i_key[2*j]) begin
                n_key[j] = i_key[2*j+1];
                n_sel[j] = d8f_pkg::SEL_W'(2*j+1);
            end else begin
                n_key[j] = i_key[2*j];
                n_sel[j] = d8f_pkg::SEL_W'(2*j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_d) begin
            for (int j = 0; j < HALF; j++) begin
                r_key[j] <= n_key[j];
                r_sel[j] <= n_sel[j];
            end
        end
    end

    always_comb begin
        if (r_key[1] > r_key[0]) begin
            lo_key = r_key[1];
            lo_sel = r_sel[1];
        end else begin
            lo_key = r_key[0];
            lo_sel = r_sel[0];
        end
        if (r_key[3] > r_key[2]) begin
            hi_key = r_key[3];
            hi_sel = r_sel[3];
        end else begin
            hi_key = r_key[2];
            hi_sel = r_sel[2];
        end
        best_sel = (hi_key > lo_key) ? hi_sel : lo_sel;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_o) begin
            r_direction <= i_interior ? {1'b0, best_sel} : d8f_pkg::NO_FLOW;
        end
    end

    assign o_direction = r_direction;

endmodule

`default_nettype wire
